@@ rtl/lsd_radix_sort_permutation_assert.svh @@
// ----------------------------------------------------------------------------
// LSD radix sort permutation: assertion macros
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef LSD_RADIX_SORT_PERMUTATION_ASSERT_SVH
`define LSD_RADIX_SORT_PERMUTATION_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle property
`define LRSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// antecedent this cycle, consequent next cycle
`define LRSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);
`else
`define LRSP_ASSERT(lbl, prop, msg)
`define LRSP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/lrsp_pkg.sv @@
// ----------------------------------------------------------------------------
// lrsp_pkg
// Shared constants, datapath opcodes and control/status structs.
// ----------------------------------------------------------------------------
package lrsp_pkg;

  localparam int MAX_STRINGS   = 64;
  localparam int MAX_LENGTH    = 64;
  localparam int ALPHABET_SIZE = 26;

  localparam int DATA_W   = 7;                          // config and index fields
  localparam int ORDER_W  = $clog2(MAX_STRINGS);        // string number
  localparam int ROW_W    = $clog2(MAX_LENGTH);         // character position
  localparam int CNT_W    = $clog2(MAX_STRINGS + 1);    // letter count
  localparam int LETTER_W = $clog2(ALPHABET_SIZE);
  localparam int CFG_IDX_W = 2;
  localparam int LETTER_DEPTH = MAX_STRINGS * MAX_LENGTH;

  localparam logic [DATA_W-1:0] CODE_FIRST = 7'd97;     // 'a'
  localparam logic [DATA_W-1:0] CODE_LAST  = 7'd122;    // 'z'

  localparam logic [CFG_IDX_W-1:0] REG_NUM_STRINGS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRING_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_COUNT   = 2'd2;

  typedef enum logic [3:0] {
    OP_IDLE    = 4'd0,
    OP_LOAD    = 4'd1,
    OP_CLEAR   = 4'd2,
    OP_LET_RD  = 4'd3,
    OP_COUNT   = 4'd4,
    OP_PREFIX  = 4'd5,
    OP_SCATTER = 4'd6,
    OP_SWAP    = 4'd7,
    OP_OUT_LD  = 4'd8
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [ORDER_W-1:0]  idx;
    logic [LETTER_W-1:0] alpha;
  } cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] n_eff;
    logic [DATA_W-1:0] phases;
    logic              load_done;
    logic              out_taken;
  } status_t;

endpackage

@@ rtl/lrsp_ram.sv @@
// ----------------------------------------------------------------------------
// lrsp_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lrsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/lrsp_dp.sv @@
// ----------------------------------------------------------------------------
// lrsp_dp
// Datapath: config registers, letter store, ping-pong order stores,
// letter histogram and the output register.
// ----------------------------------------------------------------------------
module lrsp_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  lrsp_pkg::cmd_t                     cmd_i,
  output lrsp_pkg::status_t                  status_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [lrsp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [lrsp_pkg::DATA_W-1:0]        cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [lrsp_pkg::DATA_W-1:0]        letter_code_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [lrsp_pkg::DATA_W-1:0]        string_index_o,
  output logic                               last_index_o
);

  localparam int DW = lrsp_pkg::DATA_W;
  localparam int OW = lrsp_pkg::ORDER_W;
  localparam int RW = lrsp_pkg::ROW_W;
  localparam int CW = lrsp_pkg::CNT_W;
  localparam int LW = lrsp_pkg::LETTER_W;

  function automatic logic [LW-1:0] letter_of(input logic [DW-1:0] code);
    logic [DW-1:0] diff;
    begin
      diff = code - lrsp_pkg::CODE_FIRST;
      if (code < lrsp_pkg::CODE_FIRST) begin
        letter_of = '0;
      end else if (code > lrsp_pkg::CODE_LAST) begin
        letter_of = LW'(lrsp_pkg::ALPHABET_SIZE - 1);
      end else begin
        letter_of = diff[LW-1:0];
      end
    end
  endfunction

  // config
  logic [DW-1:0] num_q, num_d, len_q, len_d, phc_q, phc_d;
  logic [DW-1:0] n_eff, len_eff, phases;
  logic          cfg_acc, cfg_hit;

  // load position
  logic [OW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic          in_acc, col_last, load_last;

  // sort
  logic [RW-1:0] pos_q, pos_d;
  logic          ident_q, ident_d, sel_q, sel_d;
  logic [OW-1:0] s_q;
  logic [OW-1:0] ord_rd_a, ord_rd_b, ord_rd, order_val;
  logic [LW-1:0] letter_rd;
  logic          we_a, we_b;

  logic [CW-1:0] counts_q [lrsp_pkg::ALPHABET_SIZE];
  logic [CW-1:0] acc_q, acc_sum, cnt_rd, cnt_dec;
  logic [LW-1:0] cnt_addr;

  // output register
  logic          out_valid_q, out_valid_d, out_taken;
  logic [DW-1:0] out_idx_q;
  logic          out_last_q;

  // ---- configuration ----
  assign cfg_ready_o = (cmd_i.op == lrsp_pkg::OP_LOAD);
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;

  always_comb begin
    num_d   = num_q;
    len_d   = len_q;
    phc_d   = phc_q;
    cfg_hit = 1'b0;
    if (cfg_acc) begin
      case (cfg_index_i)
        lrsp_pkg::REG_NUM_STRINGS: begin
          num_d   = cfg_data_i;
          cfg_hit = 1'b1;
        end
        lrsp_pkg::REG_STRING_LENGTH: begin
          len_d   = cfg_data_i;
          cfg_hit = 1'b1;
        end
        lrsp_pkg::REG_PHASE_COUNT: begin
          phc_d   = cfg_data_i;
          cfg_hit = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  assign n_eff   = (num_q == '0) ? DW'(1) :
                   (num_q > DW'(lrsp_pkg::MAX_STRINGS)) ? DW'(lrsp_pkg::MAX_STRINGS) : num_q;
  assign len_eff = (len_q == '0) ? DW'(1) :
                   (len_q > DW'(lrsp_pkg::MAX_LENGTH)) ? DW'(lrsp_pkg::MAX_LENGTH) : len_q;
  assign phases  = (phc_q > len_eff) ? len_eff : phc_q;

  // ---- loading, position-major ----
  // letters wait while a register write is offered
  assign in_stall_o = (cmd_i.op != lrsp_pkg::OP_LOAD) || cfg_valid_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign col_last   = (DW'(col_q) == n_eff - DW'(1));
  assign load_last  = col_last && (DW'(row_q) == len_eff - DW'(1));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_hit) begin
      col_d = '0;
      row_d = '0;
    end else if (in_acc) begin
      if (load_last) begin
        col_d = '0;
        row_d = '0;
      end else if (col_last) begin
        col_d = '0;
        row_d = row_q + RW'(1);
      end else begin
        col_d = col_q + OW'(1);
      end
    end
  end

  // ---- phase bookkeeping ----
  always_comb begin
    pos_d   = pos_q;
    ident_d = ident_q;
    sel_d   = sel_q;
    if (in_acc && load_last && !cfg_hit) begin
      pos_d   = RW'(len_eff - DW'(1));
      ident_d = 1'b1;
    end else if (cmd_i.op == lrsp_pkg::OP_SWAP) begin
      pos_d   = pos_q - RW'(1);
      ident_d = 1'b0;
      sel_d   = !sel_q;
    end
  end

  // order entry being visited: identity before the first phase
  assign ord_rd    = sel_q ? ord_rd_b : ord_rd_a;
  assign order_val = ident_q ? cmd_i.idx : ord_rd;

  // ---- histogram ----
  assign cnt_addr = (cmd_i.op == lrsp_pkg::OP_PREFIX) ? cmd_i.alpha : letter_rd;
  assign cnt_rd   = counts_q[cnt_addr];
  assign acc_sum  = acc_q + cnt_rd;
  assign cnt_dec  = cnt_rd - CW'(1);

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      lrsp_pkg::OP_CLEAR: begin
        for (int a = 0; a < lrsp_pkg::ALPHABET_SIZE; a++) begin
          counts_q[a] <= '0;
        end
        acc_q <= '0;
      end
      lrsp_pkg::OP_COUNT: begin
        counts_q[cnt_addr] <= cnt_rd + CW'(1);
      end
      lrsp_pkg::OP_PREFIX: begin
        counts_q[cnt_addr] <= acc_sum;
        acc_q              <= acc_sum;
      end
      lrsp_pkg::OP_SCATTER: begin
        counts_q[cnt_addr] <= cnt_dec;
      end
      default: begin
      end
    endcase
    if (cmd_i.op == lrsp_pkg::OP_LET_RD) begin
      s_q <= order_val;
    end
    if (cmd_i.op == lrsp_pkg::OP_OUT_LD) begin
      out_idx_q  <= DW'(order_val) + DW'(1);
      out_last_q <= (DW'(cmd_i.idx) == n_eff - DW'(1));
    end
  end

  assign we_a = (cmd_i.op == lrsp_pkg::OP_SCATTER) && sel_q;
  assign we_b = (cmd_i.op == lrsp_pkg::OP_SCATTER) && !sel_q;

  lrsp_ram #(
    .WIDTH(LW),
    .DEPTH(lrsp_pkg::LETTER_DEPTH)
  ) u_letter_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i ({row_q, col_q}),
    .wdata_i (letter_of(letter_code_i)),
    .raddr_i ({pos_q, order_val}),
    .rdata_o (letter_rd)
  );

  lrsp_ram #(
    .WIDTH(OW),
    .DEPTH(lrsp_pkg::MAX_STRINGS)
  ) u_order_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (cnt_dec[OW-1:0]),
    .wdata_i (s_q),
    .raddr_i (cmd_i.idx),
    .rdata_o (ord_rd_a)
  );

  lrsp_ram #(
    .WIDTH(OW),
    .DEPTH(lrsp_pkg::MAX_STRINGS)
  ) u_order_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (cnt_dec[OW-1:0]),
    .wdata_i (s_q),
    .raddr_i (cmd_i.idx),
    .rdata_o (ord_rd_b)
  );

  // ---- output register ----
  assign out_taken = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.op == lrsp_pkg::OP_OUT_LD) begin
      out_valid_d = 1'b1;
    end else if (out_taken) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q       <= DW'(1);
      len_q       <= DW'(1);
      phc_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      ident_q     <= 1'b1;
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      num_q       <= num_d;
      len_q       <= len_d;
      phc_q       <= phc_d;
      col_q       <= col_d;
      row_q       <= row_d;
      ident_q     <= ident_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
  end

  assign out_valid_o    = out_valid_q;
  assign string_index_o = out_idx_q;
  assign last_index_o   = out_last_q;

  always_comb begin
    status_o.n_eff     = n_eff;
    status_o.phases    = phases;
    status_o.load_done = in_acc && load_last && !cfg_hit;
    status_o.out_taken = out_taken;
  end

endmodule

@@ rtl/lrsp_ctrl.sv @@
// ----------------------------------------------------------------------------
// lrsp_ctrl
// Sequencer: load, per-phase clear/histogram/prefix/scatter/swap, emit.
// ----------------------------------------------------------------------------
`include "lsd_radix_sort_permutation_assert.svh"

module lrsp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lrsp_pkg::status_t status_i,
  output lrsp_pkg::cmd_t    cmd_o
);

  localparam int DW = lrsp_pkg::DATA_W;
  localparam int OW = lrsp_pkg::ORDER_W;
  localparam int LW = lrsp_pkg::LETTER_W;

  typedef enum logic [12:0] {
    ST_LOAD   = 13'b0000000000001,
    ST_CLEAR  = 13'b0000000000010,
    ST_H_ORD  = 13'b0000000000100,
    ST_H_LET  = 13'b0000000001000,
    ST_H_CNT  = 13'b0000000010000,
    ST_PREFIX = 13'b0000000100000,
    ST_S_ORD  = 13'b0000001000000,
    ST_S_LET  = 13'b0000010000000,
    ST_S_WR   = 13'b0000100000000,
    ST_SWAP   = 13'b0001000000000,
    ST_O_RD   = 13'b0010000000000,
    ST_O_LD   = 13'b0100000000000,
    ST_O_WAIT = 13'b1000000000000
  } state_e;

  state_e        state_q, state_d;
  logic [OW-1:0] idx_q, idx_d;
  logic [LW-1:0] alpha_q, alpha_d;
  logic [DW-1:0] phase_q, phase_d;
  logic          idx_last;

  assign idx_last = (DW'(idx_q) == status_i.n_eff - DW'(1));

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    alpha_d = alpha_q;
    phase_d = phase_q;
    case (state_q)
      ST_LOAD: begin
        if (status_i.load_done) begin
          idx_d   = '0;
          phase_d = '0;
          state_d = (status_i.phases == '0) ? ST_O_RD : ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        idx_d   = '0;
        alpha_d = '0;
        state_d = ST_H_ORD;
      end
      ST_H_ORD: state_d = ST_H_LET;
      ST_H_LET: state_d = ST_H_CNT;
      ST_H_CNT: begin
        if (idx_last) begin
          state_d = ST_PREFIX;
        end else begin
          idx_d   = idx_q + OW'(1);
          state_d = ST_H_ORD;
        end
      end
      ST_PREFIX: begin
        if (alpha_q == LW'(lrsp_pkg::ALPHABET_SIZE - 1)) begin
          idx_d   = OW'(status_i.n_eff - DW'(1));
          state_d = ST_S_ORD;
        end else begin
          alpha_d = alpha_q + LW'(1);
        end
      end
      ST_S_ORD: state_d = ST_S_LET;
      ST_S_LET: state_d = ST_S_WR;
      ST_S_WR: begin
        if (idx_q == '0) begin
          state_d = ST_SWAP;
        end else begin
          idx_d   = idx_q - OW'(1);
          state_d = ST_S_ORD;
        end
      end
      ST_SWAP: begin
        phase_d = phase_q + DW'(1);
        idx_d   = '0;
        state_d = (phase_q + DW'(1) == status_i.phases) ? ST_O_RD : ST_CLEAR;
      end
      ST_O_RD: state_d = ST_O_LD;
      ST_O_LD: state_d = ST_O_WAIT;
      ST_O_WAIT: begin
        if (status_i.out_taken) begin
          if (idx_last) begin
            idx_d   = '0;
            state_d = ST_LOAD;
          end else begin
            idx_d   = idx_q + OW'(1);
            state_d = ST_O_RD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd_o.idx   = idx_q;
    cmd_o.alpha = alpha_q;
    case (state_q)
      ST_LOAD:   cmd_o.op = lrsp_pkg::OP_LOAD;
      ST_CLEAR:  cmd_o.op = lrsp_pkg::OP_CLEAR;
      ST_H_LET:  cmd_o.op = lrsp_pkg::OP_LET_RD;
      ST_H_CNT:  cmd_o.op = lrsp_pkg::OP_COUNT;
      ST_PREFIX: cmd_o.op = lrsp_pkg::OP_PREFIX;
      ST_S_LET:  cmd_o.op = lrsp_pkg::OP_LET_RD;
      ST_S_WR:   cmd_o.op = lrsp_pkg::OP_SCATTER;
      ST_SWAP:   cmd_o.op = lrsp_pkg::OP_SWAP;
      ST_O_LD:   cmd_o.op = lrsp_pkg::OP_OUT_LD;
      default:   cmd_o.op = lrsp_pkg::OP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      idx_q   <= '0;
      alpha_q <= '0;
      phase_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      alpha_q <= alpha_d;
      phase_q <= phase_d;
    end
  end

  // output handshake only completes while waiting on it
  `LRSP_ASSERT(a_taken_in_wait, !status_i.out_taken || (state_q == ST_O_WAIT), "result taken outside emit wait")
  // a completed set always leaves the load state
  `LRSP_ASSERT_NEXT(a_load_exit, status_i.load_done, state_q != ST_LOAD, "sort did not start after last letter")
  // loop index stays within the string count while sorting or emitting
  `LRSP_ASSERT(a_idx_range, (state_q == ST_LOAD) || (DW'(idx_q) < status_i.n_eff), "string index out of range")

endmodule

@@ rtl/lsd_radix_sort_permutation.sv @@
// ----------------------------------------------------------------------------
// lsd_radix_sort_permutation
// LSD radix sort of equal-length lowercase strings, emitting the sorted order.
// ----------------------------------------------------------------------------
// Letters stream in position-major order (position 0 of every string, then
// position 1, ...), one per cycle while in_stall_o is low. The transaction
// carrying the last letter of the set starts the sort: phase_count stable
// counting-sort phases (saturated to string_length) run from the last
// position toward the front. Each phase runs a histogram clear, a walk per
// string through the order store and letter store (both single-read-port
// RAMs), a 26-step prefix sum over the alphabet, the same walk backward
// for the scatter, and a ping-pong swap of the order stores. Results then
// leave one at a time, each read, registered and held until taken before
// the next is fetched: string_index_o is the 1-based original index,
// last_index_o marks the final one. Input stays stalled from the last
// letter until the final result is taken; no clearing pass follows reset.
// Registers (index 0 num_strings, 1 string_length, 2 phase_count) may only
// be written while loading, and letters are held off while a write is
// offered; any write restarts loading at position zero, an index outside
// the list is ignored. Zero string counts and lengths act as one, values
// past 64 act as 64; letter codes below 'a' count as 'a', above 'z' as 'z'.
// ----------------------------------------------------------------------------
module lsd_radix_sort_permutation (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lrsp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [lrsp_pkg::DATA_W-1:0]    cfg_data_i,
  // letters in
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [lrsp_pkg::DATA_W-1:0]    letter_code_i,
  // order out
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [lrsp_pkg::DATA_W-1:0]    string_index_o,
  output logic                           last_index_o
);

  lrsp_pkg::cmd_t    cmd;
  lrsp_pkg::status_t status;

  // sequencing only; all storage lives in the datapath
  lrsp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  lrsp_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .letter_code_i  (letter_code_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .string_index_o (string_index_o),
    .last_index_o   (last_index_o)
  );

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb: bench for lsd_radix_sort_permutation
// Streams letter sets under changing string counts, lengths and pass counts,
// predicts each sorted order with a counting-sort model kept in a small
// scoreboard, and checks every index the block emits against it.
// ----------------------------------------------------------------------------
module tb;
  import lrsp_pkg::*;

  localparam int RESET_CYCLES   = 11;
  localparam int RANDOM_ITEMS   = 170;
  // Idle cycles after the last expected index before a register write or the
  // end of the run; the block goes back to loading right after its last index.
  localparam int SETTLE_CYCLES  = 8;
  // Longest legal quiet stretch is a 64-pass sort of one string or one pass
  // over 64 strings plus heavy output stalls.
  localparam int WATCHDOG_LIMIT = 20000;
  // Index past the register list: the block must ignore the write.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [DATA_W-1:0] orig_index;
    logic              is_last;
  } order_slot_t;

  typedef enum int unsigned {
    STALL_NONE,
    STALL_COIN,
    STALL_HEAVY,
    STALL_COMB
  } stall_style_e;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the register file and letter grid, runs the LSD sort
  // when a set completes and queues the expected order.
  // --------------------------------------------------------------------------
  class order_board;
    int unsigned         mismatches;
    logic [DATA_W-1:0]   str_count;
    logic [DATA_W-1:0]   str_len;
    logic [DATA_W-1:0]   pass_count;
    logic [LETTER_W-1:0] grid [MAX_LENGTH][MAX_STRINGS];  // [position][string]
    int unsigned         fill_ptr;
    order_slot_t         order_q [$];

    function new();
      str_count  = 7'd1;
      str_len    = 7'd1;
      pass_count = 7'd0;
      fill_ptr   = 0;
      mismatches = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      mismatches++;
    endtask

    // zero acts as one, anything past the maximum saturates
    function int unsigned clamp_to(logic [DATA_W-1:0] v, int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
    endfunction

    function int unsigned pending();
      return order_q.size();
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        REG_NUM_STRINGS:   str_count = data;
        REG_STRING_LENGTH: str_len = data;
        REG_PHASE_COUNT:   pass_count = data;
        default:           return;
      endcase
      fill_ptr = 0;
    endfunction

    function void note_letter(logic [DATA_W-1:0] code);
      int unsigned         n;
      int unsigned         len;
      int unsigned         passes;
      int unsigned         total;
      int unsigned         row;
      int unsigned         s;
      logic [LETTER_W-1:0] key;
      int unsigned         rank [MAX_STRINGS];
      int unsigned         shuffled [MAX_STRINGS];
      int unsigned         tally [ALPHABET_SIZE];
      n      = clamp_to(str_count, MAX_STRINGS);
      len    = clamp_to(str_len, MAX_LENGTH);
      passes = (pass_count > len) ? len : pass_count;
      total  = n * len;
      if (fill_ptr >= total) fill_ptr = 0;
      if (code < CODE_FIRST) key = '0;
      else if (code > CODE_LAST) key = LETTER_W'(ALPHABET_SIZE - 1);
      else key = LETTER_W'(code - CODE_FIRST);
      grid[fill_ptr / n][fill_ptr % n] = key;
      fill_ptr++;
      if (fill_ptr < total) return;

      // set complete: stable counting sort, last position first
      fill_ptr = 0;
      for (int i = 0; i < n; i++) rank[i] = i;
      for (int p = 0; p < passes; p++) begin
        row = len - 1 - p;
        foreach (tally[a]) tally[a] = 0;
        for (int j = 0; j < n; j++) tally[grid[row][rank[j]]]++;
        for (int a = 1; a < ALPHABET_SIZE; a++) tally[a] += tally[a - 1];
        for (int j = n; j > 0; j--) begin
          s = rank[j - 1];
          tally[grid[row][s]]--;
          shuffled[tally[grid[row][s]]] = s;
        end
        for (int j = 0; j < n; j++) rank[j] = shuffled[j];
      end
      for (int k = 0; k < n; k++)
        order_q.push_back('{orig_index: DATA_W'(rank[k] + 1), is_last: (k == n - 1)});
    endfunction

    task check_result(logic [DATA_W-1:0] idx_seen, logic last_seen);
      order_slot_t want;
      if (order_q.size() == 0) begin
        report($sformatf("unexpected index %0d last %0b", idx_seen, last_seen));
        return;
      end
      want = order_q.pop_front();
      if (idx_seen !== want.orig_index)
        report($sformatf("string_index got %0d want %0d", idx_seen, want.orig_index));
      if (last_seen !== want.is_last)
        report($sformatf("last_index got %0b want %0b", last_seen, want.is_last));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block inputs, all known from time zero
  // --------------------------------------------------------------------------
  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [DATA_W-1:0]    cfg_data_i    = '0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_stall_o;
  logic [DATA_W-1:0]    letter_code_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i   = 1'b0;
  logic [DATA_W-1:0]    string_index_o;
  logic                 last_index_o;

  order_board   board = new();
  int unsigned  burst_left   = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  stall_run    = 0;
  stall_style_e stall_style  = STALL_NONE;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  lsd_radix_sort_permutation u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .letter_code_i  (letter_code_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .string_index_o (string_index_o),
    .last_index_o   (last_index_o)
  );

  // --------------------------------------------------------------------------
  // Monitor: every transaction is taken from values sampled at the edge.
  // Register writes and letters feed the scoreboard, indexes are checked.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) board.note_config(cfg_index_i, cfg_data_i);
      if (in_valid_i && !in_stall_o) board.note_letter(letter_code_i);
      if (out_valid_o && !out_stall_i) board.check_result(string_index_o, last_index_o);
    end
  end

  // Watchdog: too long without any transaction on any channel ends the run.
  always @(posedge clk_i) begin
    if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && !in_stall_o) ||
        (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Output side: stall pattern switches between segments of free flow, coin
  // flips, near-solid stall and a periodic comb.
  always @(posedge clk_i) begin
    if (stall_run == 0) begin
      stall_style <= stall_style_e'($urandom_range(0, 3));
      stall_run   <= $urandom_range(10, 120);
      out_stall_i <= 1'b0;
    end else begin
      stall_run <= stall_run - 1;
      case (stall_style)
        STALL_NONE:  out_stall_i <= 1'b0;
        STALL_COIN:  out_stall_i <= ($urandom_range(0, 1) == 0);
        STALL_HEAVY: out_stall_i <= ($urandom_range(0, 7) != 0);
        default:     out_stall_i <= ((stall_run % 16) < 5);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // One letter transaction. The sender runs in bursts; between bursts valid
  // drops for a random gap (sometimes none, sometimes long gap-free runs).
  task automatic send_letter(input logic [DATA_W-1:0] code);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 2) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    letter_code_i <= code;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Leaves cfg_valid_i high so back-to-back writes never drop it; the caller
  // lowers it after the last write of a group.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic configure(input logic [DATA_W-1:0] count, input logic [DATA_W-1:0] len,
                           input logic [DATA_W-1:0] passes);
    write_reg(REG_NUM_STRINGS, count);
    write_reg(REG_STRING_LENGTH, len);
    write_reg(REG_PHASE_COUNT, passes);
    cfg_valid_i <= 1'b0;
  endtask

  // Stop sending, wait for the whole expected order, then let the block settle.
  // The first edge is waited before looking so the monitor has seen the last
  // letter.
  task automatic finish_set();
    in_valid_i <= 1'b0;
    burst_left  = 0;
    do @(posedge clk_i); while (board.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Mostly real letters, often from a three-letter subset to force ties,
  // sometimes any 7-bit code so the clamping is exercised.
  function automatic logic [DATA_W-1:0] pick_code();
    case ($urandom_range(0, 9))
      0, 1:    return DATA_W'($urandom_range(0, 127));
      2, 3, 4: return DATA_W'($urandom_range(CODE_FIRST, CODE_FIRST + 2));
      default: return DATA_W'($urandom_range(CODE_FIRST, CODE_LAST));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [DATA_W-1:0] want_n;
    logic [DATA_W-1:0] want_len;
    logic [DATA_W-1:0] want_ph;
    int unsigned       set_letters;
    int unsigned       sent;
    int unsigned       partial;
    int unsigned       sets;
    int unsigned       round;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset setting: one string of one letter, code below 'a'.
    send_letter(7'd0);
    finish_set();

    // Three strings of two letters, both positions sorted; second row has
    // codes below 'a' and above 'z' next to a real 'z'.
    configure(7'd3, 7'd2, 7'd2);
    send_letter(7'd98); send_letter(7'd97);  send_letter(7'd98);
    send_letter(7'd0);  send_letter(7'd127); send_letter(7'd122);
    finish_set();

    // Writes in the middle of a load: the out-of-list index must not restart
    // loading, the pass count write must (and saturates 127 to the length).
    configure(7'd2, 7'd2, 7'd1);
    send_letter(7'd99);
    write_reg(REG_UNUSED, 7'h55);
    cfg_valid_i <= 1'b0;
    send_letter(7'd120);
    write_reg(REG_PHASE_COUNT, 7'd127);
    cfg_valid_i <= 1'b0;
    send_letter(7'd122); send_letter(7'd97); send_letter(7'd97); send_letter(7'd98);
    finish_set();

    // Zero string count and zero length both act as one.
    configure(7'd0, 7'd0, 7'd5);
    send_letter(7'd127);
    finish_set();

    // Single-letter strings with ties; the sort must stay stable.
    configure(7'd4, 7'd1, 7'd1);
    send_letter(7'd100); send_letter(7'd99); send_letter(7'd100); send_letter(7'd97);
    finish_set();

    // Fewer passes than positions: only the last position decides.
    configure(7'd2, 7'd3, 7'd1);
    send_letter(7'd97);  send_letter(7'd98);
    send_letter(7'd99);  send_letter(7'd97);
    send_letter(7'd122); send_letter(7'd122);
    finish_set();

    // Random settings. Round 1 saturates the string count to 64, round 3
    // uses the longest strings with the pass count saturated to 64.
    round = 0;
    sent  = 0;
    while (sent < RANDOM_ITEMS) begin
      case (round)
        1: begin
          want_n   = 7'd127;
          want_len = 7'd1;
          want_ph  = 7'd1;
        end
        3: begin
          want_n   = 7'd1;
          want_len = 7'd64;
          want_ph  = 7'd127;
        end
        default: begin
          want_n   = DATA_W'($urandom_range(0, 8));
          want_len = DATA_W'($urandom_range(0, 6));
          want_ph  = DATA_W'($urandom_range(0, 7));
        end
      endcase
      set_letters = board.clamp_to(want_n, MAX_STRINGS) * board.clamp_to(want_len, MAX_LENGTH);
      configure(want_n, want_len, want_ph);

      // Now and then a broken load: part of a set, then either a restarting
      // rewrite of the string count or an ignored write that leaves the
      // partial set in place to be completed.
      partial = 0;
      if ($urandom_range(0, 4) == 0 && set_letters > 1) begin
        partial = $urandom_range(1, set_letters - 1);
        repeat (partial) send_letter(pick_code());
        sent += partial;
        if ($urandom_range(0, 1) == 0) begin
          write_reg(REG_NUM_STRINGS, want_n);
          partial = 0;
        end else begin
          write_reg(REG_UNUSED, DATA_W'($urandom));
        end
        cfg_valid_i <= 1'b0;
      end

      // Back-to-back sets under one setting: the next set waits on the
      // input stall while the previous order drains.
      sets = (round == 1 || round == 3) ? 1 : $urandom_range(1, 3);
      for (int s = 0; s < sets; s++) begin
        repeat (set_letters - partial) send_letter(pick_code());
        sent += set_letters - partial;
        partial = 0;
      end
      finish_set();
      round++;
    end

    if (board.mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
